// ----- sv/dsvf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dsvf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] RegVolume      = 3'd0;
  localparam logic [2:0] RegDamping     = 3'd1;
  localparam logic [2:0] RegCutoffStart = 3'd2;
  localparam logic [2:0] RegDetuneStep  = 3'd3;
  localparam logic [2:0] RegOutputMode  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [14:0] VolumeReset      = 15'd32000;
  localparam logic [14:0] DampingReset     = 15'd10000;
  localparam logic [14:0] CutoffStartReset = 15'd9000;
  localparam logic [19:0] DetuneStepReset  = 20'd40000;

  // The cutoff slides down only while it is above this floor.
  localparam logic [14:0] CutoffFloor = 15'd4000;

  // Output tap selection.
  localparam logic ModeHighpass = 1'b0;

  // Multiplier operand pairs.
  typedef enum logic [1:0] {
    MUL_VOL_SIG,
    MUL_F_BP,
    MUL_Q_BP,
    MUL_F_HP
  } mul_sel_e;

  // Accumulator operations.
  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_SIG,
    ALU_LP,
    ALU_HP,
    ALU_BP
  } alu_op_e;

  // One control word of the program.
  typedef struct packed {
    logic     mul_en;
    mul_sel_e mul_sel;
    alu_op_e  alu_op;
    logic     last;
  } ctrl_word_t;

  localparam logic [2:0] LastStep = 3'd5;

  // Program ROM: one control word per step. The product of a step is
  // registered and consumed by the accumulator operation of a later step.
  function automatic ctrl_word_t ucode(input logic [2:0] step);
    ctrl_word_t cw;
    cw = '{mul_en: 1'b0, mul_sel: MUL_VOL_SIG, alu_op: ALU_NOP, last: 1'b0};
    unique case (step)
      3'd0: cw = '{mul_en: 1'b1, mul_sel: MUL_VOL_SIG, alu_op: ALU_NOP, last: 1'b0};
      3'd1: cw = '{mul_en: 1'b1, mul_sel: MUL_F_BP,    alu_op: ALU_SIG, last: 1'b0};
      3'd2: cw = '{mul_en: 1'b1, mul_sel: MUL_Q_BP,    alu_op: ALU_LP,  last: 1'b0};
      3'd3: cw = '{mul_en: 1'b0, mul_sel: MUL_F_HP,    alu_op: ALU_HP,  last: 1'b0};
      3'd4: cw = '{mul_en: 1'b1, mul_sel: MUL_F_HP,    alu_op: ALU_NOP, last: 1'b0};
      3'd5: cw = '{mul_en: 1'b0, mul_sel: MUL_F_HP,    alu_op: ALU_BP,  last: 1'b1};
      default: cw = '{mul_en: 1'b0, mul_sel: MUL_VOL_SIG, alu_op: ALU_NOP, last: 1'b1};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dual_saw_state_variable_filter_voice.sv -----
// A sample beat accepted shows its result on mix_out_o once the last program step has written it.
// Each sample runs a six-step program that passes its four products through one shared 16x32
// multiplier; the block takes no new sample before the last step of the current one.
// The last step and the next accept share a cycle; a held result stalls the last step and input.
// Reset (rst_ni low, asynchronous) restores the register defaults, clears oscillators,
// filter integrators and sample counter, and loads the cutoff with its start value.
`timescale 1ns / 1ps
`default_nettype none

module dual_saw_state_variable_filter_voice
  import dsvf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Sample input channel.
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [30:0]        phase_step_i,
  input  wire logic               note_active_i,
  input  wire logic               row_start_i,
  input  wire logic signed [15:0] mix_in_i,
  // Result channel.
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      mix_out_o,
  // Configuration write channel.
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [19:0]        cfg_data_i
);

  // Configuration registers.
  logic [14:0] volume_q, damping_q, cutoff_start_q;
  logic [19:0] detune_step_q;
  logic        output_mode_q;

  // Voice state.
  logic [31:0] phase_a_q, phase_b_q;
  logic [31:0] lp_q, bp_q, hp_q;
  logic [14:0] cutoff_q, cutoff_d;
  logic [1:0]  count_q;

  // Sequencer and per-sample latches.
  logic        busy_q;
  logic [2:0]  step_q;
  logic        active_q;
  logic [15:0] mix_q;
  logic signed [47:0] prod_q;

  // Result register.
  logic        out_valid_q;
  logic [15:0] mix_out_q;

  ctrl_word_t  cw;
  logic        step_en;
  logic        in_accept;
  logic        out_accept;
  logic        cfg_write;

  assign cw = ucode(step_q);

  // The last step writes the result register, so it waits while a result is held.
  assign step_en    = busy_q && !(cw.last && out_valid_q && out_stall_i);
  assign in_stall_o = busy_q && !(cw.last && step_en);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  assign out_valid_o = out_valid_q;
  assign mix_out_o   = mix_out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q       <= VolumeReset;
      damping_q      <= DampingReset;
      cutoff_start_q <= CutoffStartReset;
      detune_step_q  <= DetuneStepReset;
      output_mode_q  <= ModeHighpass;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        RegVolume:      volume_q       <= cfg_data_i[14:0];
        RegDamping:     damping_q      <= cfg_data_i[14:0];
        RegCutoffStart: cutoff_start_q <= cfg_data_i[14:0];
        RegDetuneStep:  detune_step_q  <= cfg_data_i;
        RegOutputMode:  output_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Cutoff reload on a row start and slow downward slide.
  always_comb begin
    logic [14:0] base;
    base = row_start_i ? cutoff_start_q : cutoff_q;
    if (base > CutoffFloor && count_q[1]) begin
      cutoff_d = base - 15'd1;
    end else begin
      cutoff_d = base;
    end
  end

  // Per-sample front end: oscillators, cutoff and counter advance at the accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_a_q <= '0;
      phase_b_q <= '0;
      cutoff_q  <= CutoffStartReset;
      count_q   <= '0;
    end else if (in_accept) begin
      phase_a_q <= phase_a_q + {1'b0, phase_step_i};
      phase_b_q <= phase_b_q + {1'b0, phase_step_i} + {12'd0, detune_step_q};
      cutoff_q  <= cutoff_d;
      count_q   <= count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      active_q <= note_active_i;
      mix_q    <= mix_in_i;
    end
  end

  // Step counter: advances each enabled step, returns to the start after the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (in_accept) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (step_en) begin
      if (cw.last) begin
        busy_q <= 1'b0;
        step_q <= '0;
      end else begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  // Summed saw tops, sign extended.
  logic signed [12:0] saw_sum;
  assign saw_sum = $signed({phase_a_q[31], phase_a_q[31:20]})
                 + $signed({phase_b_q[31], phase_b_q[31:20]});

  // Shared multiplier operand selection.
  logic signed [15:0] mul_a;
  logic signed [31:0] mul_b;
  always_comb begin
    unique case (cw.mul_sel)
      MUL_VOL_SIG: begin
        mul_a = $signed({1'b0, volume_q});
        mul_b = {{19{saw_sum[12]}}, saw_sum};
      end
      MUL_F_BP: begin
        mul_a = $signed({1'b0, cutoff_q});
        mul_b = $signed(bp_q);
      end
      MUL_Q_BP: begin
        mul_a = $signed({1'b0, damping_q});
        mul_b = $signed(bp_q);
      end
      MUL_F_HP: begin
        mul_a = $signed({1'b0, cutoff_q});
        mul_b = $signed(hp_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (step_en && cw.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Scaled products, wrapped to 32 bits.
  logic [31:0] prod_sh15, prod_sh14;
  assign prod_sh15 = prod_q[46:15];
  assign prod_sh14 = prod_q[45:14];

  // Filter integrators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0;
      bp_q <= '0;
    end else if (step_en) begin
      if (cw.alu_op == ALU_LP) begin
        lp_q <= lp_q + prod_sh15;
      end
      if (cw.alu_op == ALU_BP) begin
        bp_q <= bp_q + prod_sh15;
      end
    end
  end

  // Working register: scaled oscillator sum, then the highpass value.
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      if (cw.alu_op == ALU_SIG) begin
        hp_q <= prod_sh14;
      end else if (cw.alu_op == ALU_HP) begin
        hp_q <= hp_q - prod_sh15 - lp_q;
      end
    end
  end

  // Result register: the selected tap is added to the mix sample while the note is active.
  logic [31:0] tap;
  assign tap = (output_mode_q == ModeHighpass) ? hp_q : lp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en && cw.last) begin
      out_valid_q <= 1'b1;
    end else if (out_accept) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && cw.last) begin
      mix_out_q <= active_q ? (mix_q + tap[15:0]) : mix_q;
    end
  end

`ifndef SYNTHESIS
  // An accepted beat starts the program at its first step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (busy_q && step_q == '0))
    else $error("program did not start at step zero");

  // The step counter rests at zero while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (step_q == '0))
    else $error("step counter moved while idle");

  // The program never runs past its last step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= LastStep))
    else $error("step counter beyond program end");

  // Finishing the last step always leaves a result to deliver.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && cw.last) |=> out_valid_q)
    else $error("finished sample produced no result");

  // The bandpass integrator changes only in its own step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_en && cw.alu_op == ALU_BP) |=> $stable(bp_q))
    else $error("bandpass integrator changed outside its step");
`endif

endmodule

`default_nettype wire
